// ===== rtl/apfm_pkg.sv =====
// shared types, codes and constants of the autoranging pulse frequency meter
package apfm_pkg;

  typedef struct packed {
    logic pin_level;
    logic start_req;
  } in_word_t;

  typedef struct packed {
    logic [31:0] average_value;
    logic [24:0] autoscale_target;
    logic [1:0]  status;
  } out_word_t;

  // configuration register indexes
  localparam logic [1:0] CFG_POLL_TIME        = 2'd0;
  localparam logic [1:0] CFG_ITERATIONS       = 2'd1;
  localparam logic [1:0] CFG_TICK_PERIOD      = 2'd2;
  localparam logic [1:0] CFG_PRESENCE_TIMEOUT = 2'd3;

  localparam int CFG_W = 27;

  localparam logic [26:0] POLL_RESET     = 27'd150000;
  localparam logic [9:0]  ITER_RESET     = 10'd5;
  localparam logic [9:0]  TICK_RESET     = 10'd10;
  localparam logic [23:0] PRESENCE_RESET = 24'd100000;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_SENSOR = 2'd1;
  localparam logic [1:0] STATUS_LIMIT     = 2'd2;

  localparam int          TICKS_W    = 40;
  localparam int          NS_W       = 50;
  localparam int          SCALE_W    = 28;
  localparam logic [9:0]  US_TO_NS   = 10'd1000;
  // 1e6 ns per ms times 256 for the q.8 fraction
  localparam logic [27:0] RATE_SCALE = 28'd256000000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRESENCE,
    S_AUTORANGE,
    S_MEASURE,
    S_MUL,
    S_RUN_DIV_GO,
    S_RUN_DIV_WAIT,
    S_ACC,
    S_CHECK,
    S_AVG_WAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic arm;
    logic tick_step;
    logic pres_ok;
    logic pres_fail;
    logic run_step;
    logic range_double;
    logic range_cap;
    logic range_done;
    logic run_latch;
    logic mul;
    logic div_run;
    logic acc;
    logic div_avg;
    logic load_avg;
  } cmd_t;

  typedef struct packed {
    logic pin;
    logic start;
    logic pres_timeout;
    logic run_end;
    logic long_enough;
    logic target_max;
    logic runs_done;
    logic div_busy;
  } sts_t;

endpackage

// ===== rtl/autoranging_pulse_frequency_meter.sv =====
// top level of the autoranging pulse frequency meter
// one word (pin sample) per cycle while idle, checking presence or counting a run;
// presence checking waits for room in the result register. After each measurement run input stalls
// through the multiply, divide and accumulate states: the shared restoring divider produces one quotient bit per cycle
// the final average goes through the same divider
// synchronous active-high reset returns the control, counter and configuration registers to their defaults
module autoranging_pulse_frequency_meter #(
  parameter int MAX_TARGET = 16777216,
  parameter int MAX_RUNS   = 1000
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  apfm_pkg::in_word_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output apfm_pkg::out_word_t        out_data,
  input  logic                       cfg_wr_en,
  input  logic [1:0]                 cfg_index,
  input  logic [apfm_pkg::CFG_W-1:0] cfg_data
);

  apfm_pkg::cmd_t cmd;
  apfm_pkg::sts_t sts;

  apfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready),
    .out_valid(out_valid)
  );

  apfm_datapath #(
    .MAX_TARGET(MAX_TARGET),
    .MAX_RUNS  (MAX_RUNS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== rtl/apfm_div.sv =====
// restoring divider, one quotient bit per cycle
module apfm_div #(
  parameter int N_W = 53,
  parameter int D_W = 50
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           busy,
  output logic [N_W-1:0] quotient
);

  localparam int CW = $clog2(N_W + 1);

  logic [D_W-1:0] rem;
  logic [N_W-1:0] quo;
  logic [D_W-1:0] dvs;
  logic [CW-1:0]  cnt;
  logic [D_W:0]   trial;
  logic [D_W:0]   diff;
  logic           ge;

  assign trial = {rem, quo[N_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CW'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
      cnt <= CW'(N_W);
    end else if (busy) begin
      rem <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
      quo <= {quo[N_W-2:0], ge};
      cnt <= cnt - CW'(1);
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/apfm_datapath.sv =====
// counters, range target, run accumulation and result register of the meter
module apfm_datapath #(
  parameter int MAX_TARGET = 16777216,
  parameter int MAX_RUNS   = 1000
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [1:0]                   cfg_index,
  input  logic [apfm_pkg::CFG_W-1:0]   cfg_data,
  input  apfm_pkg::in_word_t           in_data,
  input  apfm_pkg::cmd_t               cmd,
  output apfm_pkg::sts_t               sts,
  output apfm_pkg::out_word_t          out_data
);

  localparam int TW   = $clog2(MAX_TARGET + 1);
  localparam int EW   = TW + 1;
  localparam int RW   = $clog2(MAX_RUNS + 1);
  localparam int NUMW = TW + apfm_pkg::SCALE_W;
  localparam int SUMW = 32 + RW;
  localparam int DIVW = (NUMW > SUMW) ? NUMW : SUMW;
  localparam int NSW  = apfm_pkg::NS_W;
  localparam int TKW  = apfm_pkg::TICKS_W;

  logic [26:0] poll_time_us;
  logic [9:0]  iteration_count;
  logic [9:0]  tick_period_ns;
  logic [23:0] presence_timeout_us;

  logic          await_low;
  logic [EW-1:0] edge_count;
  logic [TKW-1:0] elapsed_ticks;
  logic [NSW-1:0] elapsed_ns;
  logic [TW-1:0] target_edges;
  logic [RW-1:0] run_index;
  logic [SUMW-1:0] value_sum;
  logic          capped;

  logic [36:0]     poll_thr;
  logic [33:0]     pres_thr;
  logic [NUMW-1:0] num;
  logic [NSW-1:0]  den;

  logic [9:0]      tick_eff;
  logic            ticks_sat;
  logic [TKW-1:0]  ticks_inc;
  logic [NSW-1:0]  ns_inc;
  logic [EW-1:0]   edge_inc;
  logic [TW:0]     target_dbl;
  logic [TW-1:0]   target_grow;
  logic [RW-1:0]   runs_n;
  logic            new_run;
  logic            div_start;
  logic [DIVW-1:0] div_dividend;
  logic [NSW-1:0]  div_divisor;
  logic [DIVW-1:0] quotient;
  logic            div_busy;
  logic [31:0]     run_value;
  logic [TW+24:0]  target_wide;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_time_us        <= apfm_pkg::POLL_RESET;
      iteration_count     <= apfm_pkg::ITER_RESET;
      tick_period_ns      <= apfm_pkg::TICK_RESET;
      presence_timeout_us <= apfm_pkg::PRESENCE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        apfm_pkg::CFG_POLL_TIME:        poll_time_us        <= cfg_data[26:0];
        apfm_pkg::CFG_ITERATIONS:       iteration_count     <= cfg_data[9:0];
        apfm_pkg::CFG_TICK_PERIOD:      tick_period_ns      <= cfg_data[9:0];
        apfm_pkg::CFG_PRESENCE_TIMEOUT: presence_timeout_us <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  assign tick_eff    = (tick_period_ns == 10'd0) ? 10'd1 : tick_period_ns;
  assign ticks_sat   = &elapsed_ticks;
  assign ticks_inc   = ticks_sat ? elapsed_ticks : elapsed_ticks + TKW'(1);
  assign ns_inc      = ticks_sat ? elapsed_ns : elapsed_ns + NSW'(tick_eff);
  assign edge_inc    = edge_count + EW'(1);
  assign target_dbl  = {target_edges, 1'b0};
  assign target_grow = (target_dbl > (TW+1)'(MAX_TARGET)) ? TW'(MAX_TARGET)
                                                         : target_dbl[TW-1:0];

  always_comb begin
    if (iteration_count == 10'd0) begin
      runs_n = RW'(1);
    end else if ({22'd0, iteration_count} > 32'(MAX_RUNS)) begin
      runs_n = RW'(MAX_RUNS);
    end else begin
      runs_n = RW'(iteration_count);
    end
  end

  assign new_run = cmd.arm | cmd.pres_ok | cmd.pres_fail | cmd.range_double |
                   cmd.range_cap | cmd.range_done | cmd.run_latch;

  // run state
  always_ff @(posedge clk) begin
    if (rst) begin
      await_low     <= 1'b0;
      edge_count    <= '0;
      elapsed_ticks <= '0;
      elapsed_ns    <= '0;
    end else if (new_run) begin
      await_low     <= 1'b0;
      edge_count    <= '0;
      elapsed_ticks <= '0;
      elapsed_ns    <= '0;
    end else if (cmd.tick_step) begin
      elapsed_ticks <= ticks_inc;
      elapsed_ns    <= ns_inc;
    end else if (cmd.run_step) begin
      elapsed_ticks <= ticks_inc;
      elapsed_ns    <= ns_inc;
      if (!await_low) begin
        if (in_data.pin_level) begin
          edge_count <= edge_inc;
          await_low  <= 1'b1;
        end
      end else if (!in_data.pin_level) begin
        edge_count <= edge_inc;
        await_low  <= 1'b0;
      end
    end
  end

  // range target, run count and sum
  always_ff @(posedge clk) begin
    if (rst) begin
      target_edges <= TW'(2);
      run_index    <= '0;
      value_sum    <= '0;
      capped       <= 1'b0;
    end else begin
      if (cmd.arm) begin
        target_edges <= TW'(2);
        capped       <= 1'b0;
      end else if (cmd.pres_ok) begin
        target_edges <= TW'(4);
      end else if (cmd.range_double) begin
        target_edges <= target_grow;
      end else if (cmd.range_cap) begin
        target_edges <= TW'(MAX_TARGET);
        capped       <= 1'b1;
      end
      if (cmd.arm || cmd.range_double || cmd.range_cap || cmd.range_done ||
          cmd.load_avg) begin
        run_index <= '0;
        value_sum <= '0;
      end else if (cmd.acc) begin
        run_index <= run_index + RW'(1);
        value_sum <= value_sum + SUMW'(run_value);
      end
    end
  end

  // thresholds, divider operands and result word
  always_ff @(posedge clk) begin
    if (cmd.arm) begin
      poll_thr <= 37'(poll_time_us) * 37'(apfm_pkg::US_TO_NS);
      pres_thr <= 34'(presence_timeout_us) * 34'(apfm_pkg::US_TO_NS);
    end
    if (cmd.run_latch) begin
      den <= (ns_inc == '0) ? NSW'(1) : ns_inc;
    end
    if (cmd.mul) begin
      num <= NUMW'(target_edges) * NUMW'(apfm_pkg::RATE_SCALE);
    end
    if (cmd.pres_fail) begin
      out_data.average_value    <= '0;
      out_data.autoscale_target <= '0;
      out_data.status           <= apfm_pkg::STATUS_NO_SENSOR;
    end else if (cmd.load_avg) begin
      out_data.average_value    <= quotient[31:0];
      out_data.autoscale_target <= target_wide[24:0];
      out_data.status           <= capped ? apfm_pkg::STATUS_LIMIT : apfm_pkg::STATUS_OK;
    end
  end

  assign target_wide  = (TW+25)'(target_edges);
  assign div_start    = cmd.div_run | cmd.div_avg;
  assign div_dividend = cmd.div_run ? DIVW'(num) : DIVW'(value_sum);
  assign div_divisor  = cmd.div_run ? den : NSW'(runs_n);
  // a run value beyond 32 bits saturates
  assign run_value    = (|quotient[DIVW-1:32]) ? 32'hFFFF_FFFF : quotient[31:0];

  apfm_div #(
    .N_W(DIVW),
    .D_W(NSW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .busy    (div_busy),
    .quotient(quotient)
  );

  assign sts.pin          = in_data.pin_level;
  assign sts.start        = in_data.start_req;
  assign sts.pres_timeout = ns_inc >= NSW'(pres_thr);
  assign sts.run_end      = await_low && !in_data.pin_level && (edge_inc >= EW'(target_edges));
  assign sts.long_enough  = ns_inc >= NSW'(poll_thr);
  assign sts.target_max   = target_edges >= TW'(MAX_TARGET);
  assign sts.runs_done    = run_index >= runs_n;
  assign sts.div_busy     = div_busy;

endmodule

// ===== rtl/apfm_ctrl.sv =====
// sequencing state machine of the meter
module apfm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           out_ready,
  input  apfm_pkg::sts_t sts,
  output apfm_pkg::cmd_t cmd,
  output logic           in_ready,
  output logic           out_valid
);

  apfm_pkg::state_t state;
  apfm_pkg::state_t state_next;
  logic             out_free;
  logic             accept;
  logic             out_load;

  assign out_free = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= apfm_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      apfm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (accept && sts.start) begin
          cmd.arm    = 1'b1;
          state_next = apfm_pkg::S_PRESENCE;
        end
      end
      apfm_pkg::S_PRESENCE: begin
        // a timeout may emit a word, so wait for room in the result register
        in_ready = out_free;
        if (accept) begin
          if (sts.pin) begin
            cmd.pres_ok = 1'b1;
            state_next  = apfm_pkg::S_AUTORANGE;
          end else if (sts.pres_timeout) begin
            cmd.pres_fail = 1'b1;
            out_load      = 1'b1;
            state_next    = apfm_pkg::S_IDLE;
          end else begin
            cmd.tick_step = 1'b1;
          end
        end
      end
      apfm_pkg::S_AUTORANGE: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd.run_step = 1'b1;
          if (sts.run_end) begin
            if (sts.long_enough) begin
              cmd.range_done = 1'b1;
              state_next     = apfm_pkg::S_MEASURE;
            end else if (sts.target_max) begin
              cmd.range_cap = 1'b1;
              state_next    = apfm_pkg::S_MEASURE;
            end else begin
              cmd.range_double = 1'b1;
            end
          end
        end
      end
      apfm_pkg::S_MEASURE: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd.run_step = 1'b1;
          if (sts.run_end) begin
            cmd.run_latch = 1'b1;
            state_next    = apfm_pkg::S_MUL;
          end
        end
      end
      apfm_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = apfm_pkg::S_RUN_DIV_GO;
      end
      apfm_pkg::S_RUN_DIV_GO: begin
        cmd.div_run = 1'b1;
        state_next  = apfm_pkg::S_RUN_DIV_WAIT;
      end
      apfm_pkg::S_RUN_DIV_WAIT: begin
        if (!sts.div_busy) begin
          state_next = apfm_pkg::S_ACC;
        end
      end
      apfm_pkg::S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = apfm_pkg::S_CHECK;
      end
      apfm_pkg::S_CHECK: begin
        if (sts.runs_done) begin
          cmd.div_avg = 1'b1;
          state_next  = apfm_pkg::S_AVG_WAIT;
        end else begin
          state_next = apfm_pkg::S_MEASURE;
        end
      end
      apfm_pkg::S_AVG_WAIT: begin
        if (!sts.div_busy) begin
          state_next = apfm_pkg::S_FINISH;
        end
      end
      apfm_pkg::S_FINISH: begin
        if (out_free) begin
          cmd.load_avg = 1'b1;
          out_load     = 1'b1;
          state_next   = apfm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = apfm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/apfm_checker.sv =====
// port-level checks of the meter, bound to the top level
module apfm_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input apfm_pkg::out_word_t out_data
);

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == apfm_pkg::STATUS_OK ||
                   out_data.status == apfm_pkg::STATUS_NO_SENSOR ||
                   out_data.status == apfm_pkg::STATUS_LIMIT))
    else $error("unknown status code");

  // no sensor reports carry no measurement
  a_no_sensor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == apfm_pkg::STATUS_NO_SENSOR |->
      out_data.average_value == 32'd0 && out_data.autoscale_target == 25'd0)
    else $error("no sensor word with nonzero fields");

endmodule

bind autoranging_pulse_frequency_meter apfm_checker u_apfm_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
